FILE: src/lcr_pkg.sv
`default_nettype none
package lcr_pkg;

    localparam int CoordW = 6;
    localparam int ColorW = 4;
    localparam int GlyphW = 8;
    localparam int AttrW  = 8;
    localparam int PcW    = 2;
    localparam int CondW  = 2;

    // jump conditions
    localparam logic [CondW-1:0] COND_NEVER  = 2'd0;
    localparam logic [CondW-1:0] COND_NO_IN  = 2'd1;
    localparam logic [CondW-1:0] COND_MORE   = 2'd2;
    localparam logic [CondW-1:0] COND_ALWAYS = 2'd3;

    // program addresses
    localparam logic [PcW-1:0] STEP_FETCH = 2'd0;
    localparam logic [PcW-1:0] STEP_SETUP = 2'd1;
    localparam logic [PcW-1:0] STEP_DRAW  = 2'd2;
    localparam logic [PcW-1:0] STEP_DONE  = 2'd3;

    typedef struct packed {
        logic ld_in;
        logic calc;
        logic emit;
    } t_ctrl;

    typedef struct packed {
        logic in_valid;
        logic out_free;
        logic last;
    } t_stat;

    typedef struct packed {
        t_ctrl            ctrl;
        logic [CondW-1:0] cond;
        logic [PcW-1:0]   target;
    } t_uword;

    function automatic t_uword ucode(input logic [PcW-1:0] pc);
        t_uword w;
        w = '0;
        case (pc)
            STEP_FETCH: begin
                w.ctrl.ld_in = 1'b1;
                w.cond       = COND_NO_IN;
                w.target     = STEP_FETCH;
            end
            STEP_SETUP: begin
                w.ctrl.calc = 1'b1;
                w.cond      = COND_NEVER;
                w.target    = STEP_FETCH;
            end
            STEP_DRAW: begin
                w.ctrl.emit = 1'b1;
                w.cond      = COND_MORE;
                w.target    = STEP_DRAW;
            end
            STEP_DONE: begin
                w.cond   = COND_ALWAYS;
                w.target = STEP_FETCH;
            end
            default: begin
                w.cond   = COND_ALWAYS;
                w.target = STEP_FETCH;
            end
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

FILE: src/lcr_seg_if.sv
`default_nettype none
interface lcr_seg_if
    import lcr_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CoordW-1:0] x_start;
    logic [CoordW-1:0] y_start;
    logic [CoordW-1:0] x_end;
    logic [CoordW-1:0] y_end;
    logic [GlyphW-1:0] glyph;
    logic [ColorW-1:0] back_color;
    logic [ColorW-1:0] fore_color;

    modport source (output valid, x_start, y_start, x_end, y_end, glyph, back_color,
                    fore_color, input ready);
    modport sink (input valid, x_start, y_start, x_end, y_end, glyph, back_color,
                  fore_color, output ready);
endinterface
`default_nettype wire

FILE: src/lcr_cell_if.sv
`default_nettype none
interface lcr_cell_if
    import lcr_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CoordW-1:0] cell_x;
    logic [CoordW-1:0] cell_y;
    logic [GlyphW-1:0] glyph_out;
    logic [AttrW-1:0]  attribute;
    logic              last;

    modport source (output valid, cell_x, cell_y, glyph_out, attribute, last,
                    input ready);
    modport sink (input valid, cell_x, cell_y, glyph_out, attribute, last,
                  output ready);
endinterface
`default_nettype wire

FILE: src/lcr_seq.sv
`default_nettype none
module lcr_seq
    import lcr_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  t_stat i_stat,
    output t_ctrl o_ctrl
);

    logic [PcW-1:0] r_pc;
    logic [PcW-1:0] n_pc;
    t_uword         uw;
    logic           taken;
    logic           hold;

    always_comb begin
        uw     = ucode(r_pc);
        o_ctrl = uw.ctrl;
        case (uw.cond)
            COND_NEVER:  taken = 1'b0;
            COND_NO_IN:  taken = !i_stat.in_valid;
            COND_MORE:   taken = !i_stat.last;
            COND_ALWAYS: taken = 1'b1;
            default:     taken = 1'b1;
        endcase
        hold = uw.ctrl.emit && !i_stat.out_free;
        if (hold) begin
            n_pc = r_pc;
        end else if (taken) begin
            n_pc = uw.target;
        end else begin
            n_pc = r_pc + PcW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= STEP_FETCH;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule
`default_nettype wire

FILE: src/lcr_dp.sv
`default_nettype none
module lcr_dp
    import lcr_pkg::*;
#(
    parameter int GRID_SIZE = 64
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  t_ctrl       i_ctrl,
    output t_stat       o_stat,
    lcr_seg_if.sink     i_seg,
    lcr_cell_if.source  o_cell
);

    localparam logic [CoordW-1:0] MaxCoord = CoordW'(GRID_SIZE - 1);

    function automatic logic [CoordW-1:0] clamp(input logic [CoordW-1:0] v);
        return (v > MaxCoord) ? MaxCoord : v;
    endfunction

    logic [CoordW-1:0] r_x, r_y, r_xe, r_ye;
    logic [CoordW-1:0] r_ax, r_ay, r_major, r_cnt, r_res;
    logic              r_sx, r_sy, r_xmaj;
    logic [GlyphW-1:0] r_glyph;
    logic [AttrW-1:0]  r_attr;

    logic              r_ov;
    logic [CoordW-1:0] r_ox, r_oy;
    logic [GlyphW-1:0] r_oglyph;
    logic [AttrW-1:0]  r_oattr;
    logic              r_olast;

    logic              accept;
    logic              out_free;
    logic              is_last;
    logic              go;
    logic              sx, sy;
    logic [CoordW-1:0] ax, ay;
    logic [CoordW-1:0] maj_len, min_len;
    logic [CoordW:0]   sum;
    logic              hit;
    logic              x_adv, y_adv;

    assign i_seg.ready = i_ctrl.ld_in;
    assign accept      = i_seg.valid && i_ctrl.ld_in;
    assign out_free    = !r_ov || o_cell.ready;
    assign is_last     = (r_cnt == r_major);
    assign go          = i_ctrl.emit && out_free;

    assign o_stat.in_valid = i_seg.valid;
    assign o_stat.out_free = out_free;
    assign o_stat.last     = is_last;

    always_comb begin
        sx      = r_xe > r_x;
        sy      = r_ye > r_y;
        ax      = sx ? (r_xe - r_x) : (r_x - r_xe);
        ay      = sy ? (r_ye - r_y) : (r_y - r_ye);
        maj_len = r_xmaj ? r_ax : r_ay;
        min_len = r_xmaj ? r_ay : r_ax;
        sum     = {1'b0, r_res} + {1'b0, min_len};
        hit     = sum >= {1'b0, maj_len};
        x_adv   = r_xmaj || hit;
        y_adv   = !r_xmaj || hit;
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_x     <= clamp(i_seg.x_start);
            r_y     <= clamp(i_seg.y_start);
            r_xe    <= clamp(i_seg.x_end);
            r_ye    <= clamp(i_seg.y_end);
            r_glyph <= i_seg.glyph;
            r_attr  <= {i_seg.back_color, i_seg.fore_color};
        end
        if (i_ctrl.calc) begin
            r_sx    <= sx;
            r_sy    <= sy;
            r_ax    <= ax;
            r_ay    <= ay;
            r_xmaj  <= ax > ay;
            r_major <= (ax > ay) ? ax : ay;
            r_cnt   <= '0;
            r_res   <= '0;
        end
        if (go) begin
            r_ox     <= r_x;
            r_oy     <= r_y;
            r_oglyph <= r_glyph;
            r_oattr  <= r_attr;
            r_olast  <= is_last;
            r_cnt    <= r_cnt + CoordW'(1);
            r_res    <= hit ? CoordW'(sum - {1'b0, maj_len}) : sum[CoordW-1:0];
            if (x_adv) begin
                r_x <= r_sx ? (r_x + CoordW'(1)) : (r_x - CoordW'(1));
            end
            if (y_adv) begin
                r_y <= r_sy ? (r_y + CoordW'(1)) : (r_y - CoordW'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (go) begin
            r_ov <= 1'b1;
        end else if (o_cell.ready) begin
            r_ov <= 1'b0;
        end
    end

    assign o_cell.valid     = r_ov;
    assign o_cell.cell_x    = r_ox;
    assign o_cell.cell_y    = r_oy;
    assign o_cell.glyph_out = r_oglyph;
    assign o_cell.attribute = r_oattr;
    assign o_cell.last      = r_olast;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.emit |-> r_cnt <= r_major)
        else $error("cell count ran past segment length");

    a_res_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.emit && r_major != '0) |-> r_res < maj_len)
        else $error("residual not below major length");

    a_end_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (go && is_last) |-> (r_x == r_xe && r_y == r_ye))
        else $error("last beat is not the end cell");

    a_beat_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        go |=> (r_ov && o_cell.last == $past(is_last)))
        else $error("emitted beat not captured");
`endif

endmodule
`default_nettype wire

FILE: src/line_cell_rasterizer_unit.sv
`default_nettype none
// Line cell rasterizer for a GRID_SIZE x GRID_SIZE character grid.
// i_seg (sink): one beat names a segment by start and end cell, a glyph and
//   background/foreground colors. Coordinates above GRID_SIZE-1 saturate.
// o_cell (source): one beat per cell of the segment, start to end inclusive,
//   with coordinates, glyph, attribute {back, fore} and last on the end cell.
// A small microcode program sequences the work: fetch, setup, draw loop, done.
// Timing: the segment is taken in the fetch step, deltas are formed in the
//   setup step right after, then one cell beat is produced per cycle of the
//   draw loop while o_cell is free. No new segment is taken until the block
//   has passed its done step and is back in fetch; the first cell of a
//   segment is registered into the output register in the draw step. The draw
//   loop (one major-axis step per cycle while o_cell is free) sets the rate.
// The cell output is registered; the next segment is accepted while the
//   final cell of the previous one still waits on o_cell.
// When a beat is pending and o_cell.ready is low the draw loop stalls and the pending beat holds.
// Reset (i_rst_n low, synchronous) returns the program to the fetch step and
//   empties the output register.
module line_cell_rasterizer_unit
    import lcr_pkg::*;
#(
    parameter int GRID_SIZE = 64
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    lcr_seg_if.sink    i_seg,
    lcr_cell_if.source o_cell
);

    t_ctrl ctrl;
    t_stat stat;

    lcr_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_ctrl  (ctrl)
    );

    lcr_dp #(
        .GRID_SIZE (GRID_SIZE)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (ctrl),
        .o_stat  (stat),
        .i_seg   (i_seg),
        .o_cell  (o_cell)
    );

endmodule
`default_nettype wire
